@@ rtl/timer8_prescaled_overflow_extender_defines.svh @@
// ----------------------------------------------------------------------------
// Timer assertion macros
// Shared assertion wrappers for the timer checker.
// ----------------------------------------------------------------------------
`ifndef TIMER8_PRESCALED_OVERFLOW_EXTENDER_DEFINES_SVH
`define TIMER8_PRESCALED_OVERFLOW_EXTENDER_DEFINES_SVH

// clocked assertion, disabled while reset is low
`define TPOE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, for an implication of a condition into the next cycle
`define TPOE_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/tpoe_pkg.sv @@
// ----------------------------------------------------------------------------
// tpoe_pkg
// Types, register indexes and codes shared by the timer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpoe_pkg;

  localparam int PRESCALE_BITS_DEF = 10;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int DIV_W             = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLK_SEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_ACT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRELOAD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EVT_DIV  = 3'd5;

  // compare pin actions
  localparam logic [1:0] PIN_NONE   = 2'd0;
  localparam logic [1:0] PIN_TOGGLE = 2'd1;
  localparam logic [1:0] PIN_CLEAR  = 2'd2;
  localparam logic [1:0] PIN_SET    = 2'd3;

  // clock select codes
  localparam logic [2:0] CS_STOP    = 3'd0;
  localparam logic [2:0] CS_DIV1    = 3'd1;
  localparam logic [2:0] CS_DIV8    = 3'd2;
  localparam logic [2:0] CS_DIV64   = 3'd3;
  localparam logic [2:0] CS_DIV256  = 3'd4;
  localparam logic [2:0] CS_DIV1024 = 3'd5;

  typedef struct packed {
    logic        mode;
    logic [2:0]  clock_select;
    logic [7:0]  compare_value;
    logic [1:0]  pin_action;
    logic [7:0]  preload;
    logic [31:0] events_divisor;
  } cfg_t;

  typedef struct packed {
    logic [7:0] count;
    logic       overflow;
    logic       compare_match;
    logic       pin_level;
    logic       event_res;
  } res_t;

  // prescaler divide ratio, zero means stopped
  function automatic logic [DIV_W-1:0] div_of(input logic [2:0] cs);
    logic [DIV_W-1:0] d;
    begin
      unique case (cs)
        CS_DIV1:    d = 11'd1;
        CS_DIV8:    d = 11'd8;
        CS_DIV64:   d = 11'd64;
        CS_DIV256:  d = 11'd256;
        CS_DIV1024: d = 11'd1024;
        default:    d = 11'd0;
      endcase
      return d;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/timer8_prescaled_overflow_extender.sv @@
// Path: an accepted beat is held in the input register; its result goes to the
// result register on out_*. Throughput: one beat per cycle while out_stall is low;
// these registers decouple the channels, so one beat is taken while a result waits.
// Reset: synchronous, active low; clears state, flags and config (divisor to 1).
// ----------------------------------------------------------------------------
// timer8_prescaled_overflow_extender
// 8-bit prescaled timer with normal / clear-on-compare modes, compare pin
// and an overflow/match event counter. One input beat is one source cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timer8_prescaled_overflow_extender #(
  parameter int PRESCALE_BITS = tpoe_pkg::PRESCALE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output wire logic                            in_stall,
  input  wire logic                            in_restart,
  output wire logic                            out_valid,
  input  wire logic                            out_stall,
  output wire logic [7:0]                      out_count,
  output wire logic                            out_overflow,
  output wire logic                            out_compare_match,
  output wire logic                            out_pin_level,
  output wire logic                            out_event_res,
  input  wire logic                            cfg_we,
  input  wire logic [tpoe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpoe_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tpoe_pkg::cfg_t cfg;
  tpoe_pkg::res_t res;

  logic           s1_valid_r, s1_valid_nxt;
  logic           s1_restart_r;
  logic           out_valid_r, out_valid_nxt;
  tpoe_pkg::res_t out_res_r;
  logic           out_free;
  logic           step;
  logic           in_take;

  tpoe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tpoe_core #(
    .PRESCALE_BITS (PRESCALE_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .restart (s1_restart_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    step          = s1_valid_r && out_free;
    in_take       = in_valid && (!s1_valid_r || out_free);
    s1_valid_nxt  = in_take || (s1_valid_r && !out_free);
    out_valid_nxt = step || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_restart_r <= in_restart;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign in_stall          = s1_valid_r && !out_free;
  assign out_valid         = out_valid_r;
  assign out_count         = out_res_r.count;
  assign out_overflow      = out_res_r.overflow;
  assign out_compare_match = out_res_r.compare_match;
  assign out_pin_level     = out_res_r.pin_level;
  assign out_event_res     = out_res_r.event_res;

endmodule

`default_nettype wire

@@ rtl/tpoe_cfg.sv @@
// ----------------------------------------------------------------------------
// tpoe_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpoe_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [tpoe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tpoe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output tpoe_pkg::cfg_t                          cfg
);

  tpoe_pkg::cfg_t cfg_r;
  tpoe_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tpoe_pkg::REG_MODE:    cfg_nxt.mode           = cfg_wdata[0];
        tpoe_pkg::REG_CLK_SEL: cfg_nxt.clock_select   = cfg_wdata[2:0];
        tpoe_pkg::REG_COMPARE: cfg_nxt.compare_value  = cfg_wdata[7:0];
        tpoe_pkg::REG_PIN_ACT: cfg_nxt.pin_action     = cfg_wdata[1:0];
        tpoe_pkg::REG_PRELOAD: cfg_nxt.preload        = cfg_wdata[7:0];
        tpoe_pkg::REG_EVT_DIV: cfg_nxt.events_divisor = cfg_wdata[31:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= 1'b0;
      cfg_r.clock_select   <= tpoe_pkg::CS_STOP;
      cfg_r.compare_value  <= 8'd0;
      cfg_r.pin_action     <= tpoe_pkg::PIN_NONE;
      cfg_r.preload        <= 8'd0;
      cfg_r.events_divisor <= 32'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ rtl/tpoe_core.sv @@
// ----------------------------------------------------------------------------
// tpoe_core
// Timer state and the single-pass step logic: prescaler, count, pin, events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpoe_core #(
  parameter int PRESCALE_BITS = tpoe_pkg::PRESCALE_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic            restart,
  input  wire tpoe_pkg::cfg_t  cfg,
  output tpoe_pkg::res_t       res
);

  localparam int PW = PRESCALE_BITS + 1;

  logic [PRESCALE_BITS-1:0] pre_r, pre_nxt;
  logic [7:0]               timer_r, timer_nxt;
  logic [31:0]              ev_r, ev_nxt;
  logic                     pin_r, pin_nxt;

  logic [tpoe_pkg::DIV_W-1:0] div;
  logic [PW-1:0]              pre_inc;
  logic                       tick;
  logic                       match;
  logic                       ovf;
  logic                       ev_src;
  logic [32:0]                ev_inc;
  logic                       ev_hit;
  logic                       fire;
  logic [7:0]                 cnt_base;

  always_comb begin
    div      = tpoe_pkg::div_of(cfg.clock_select);
    pre_inc  = {1'b0, pre_r} + PW'(1);
    tick     = (div != '0) && (pre_inc >= PW'(div));
    match    = tick && (timer_r == cfg.compare_value);
    ovf      = tick && (timer_r == 8'hFF);
    cnt_base = (cfg.mode && match) ? 8'd0 : timer_r + 8'd1;
    ev_src   = tick && (cfg.mode ? match : ovf);
    ev_inc   = {1'b0, ev_r} + 33'd1;
    // divisor of zero behaves as one: any count reaches it
    ev_hit   = ev_inc >= {1'b0, cfg.events_divisor};
    fire     = ev_src && ev_hit;

    pre_nxt   = pre_r;
    timer_nxt = timer_r;
    ev_nxt    = ev_r;
    pin_nxt   = pin_r;

    if (restart) begin
      pre_nxt   = '0;
      ev_nxt    = '0;
      timer_nxt = cfg.preload;
    end else if (div != '0) begin
      pre_nxt = tick ? '0 : pre_inc[PRESCALE_BITS-1:0];
      if (tick) begin
        timer_nxt = (fire && !cfg.mode) ? cfg.preload : cnt_base;
      end
      if (ev_src) begin
        ev_nxt = ev_hit ? 32'd0 : ev_inc[31:0];
      end
      if (match) begin
        unique case (cfg.pin_action)
          tpoe_pkg::PIN_TOGGLE: pin_nxt = ~pin_r;
          tpoe_pkg::PIN_CLEAR:  pin_nxt = 1'b0;
          tpoe_pkg::PIN_SET:    pin_nxt = 1'b1;
          default:              pin_nxt = pin_r;
        endcase
      end
    end

    res.count         = timer_nxt;
    res.overflow      = !restart && ovf;
    res.compare_match = !restart && match;
    res.pin_level     = pin_nxt;
    res.event_res     = !restart && fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r   <= '0;
      timer_r <= '0;
      ev_r    <= '0;
      pin_r   <= 1'b0;
    end else if (step) begin
      pre_r   <= pre_nxt;
      timer_r <= timer_nxt;
      ev_r    <= ev_nxt;
      pin_r   <= pin_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tpoe_checker.sv @@
// ----------------------------------------------------------------------------
// tpoe_checker
// Port-level checks on the timer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "timer8_prescaled_overflow_extender_defines.svh"

module tpoe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_count,
  input wire logic       out_overflow,
  input wire logic       out_compare_match,
  input wire logic       out_pin_level,
  input wire logic       out_event_res
);

  // a stalled result beat holds its count, overflow, pin level and event flag
  `TPOE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_count) && $stable(out_overflow) && $stable(out_event_res) && $stable(out_pin_level), "stalled result beat changed")

  // an event only comes from an overflow or a compare match
  `TPOE_ASSERT(a_event_src, (out_valid && out_event_res) |-> (out_overflow || out_compare_match), "event without overflow or match")

  // without a preload event, a wrap leaves the count at zero
  `TPOE_ASSERT(a_wrap_zero, (out_valid && out_overflow && !out_event_res) |-> (out_count == 8'd0), "overflow with nonzero count")

endmodule

bind timer8_prescaled_overflow_extender tpoe_checker u_tpoe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_count         (out_count),
  .out_overflow      (out_overflow),
  .out_compare_match (out_compare_match),
  .out_pin_level     (out_pin_level),
  .out_event_res     (out_event_res)
);

`default_nettype wire

@@ dv/timer8_prescaled_overflow_extender_checker.sv @@
// ----------------------------------------------------------------------------
// Timer result checker
// Watches the config port and both beat channels, keeps its own copy of the
// timer, prescaler, event counter and pin, and compares every result beat
// with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer8_prescaled_overflow_extender_checker #(
  parameter int PRESCALE_BITS = tpoe_pkg::PRESCALE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_restart,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [7:0]                      out_count,
  input  logic                            out_overflow,
  input  logic                            out_compare_match,
  input  logic                            out_pin_level,
  input  logic                            out_event_res,
  input  logic                            cfg_we,
  input  logic [tpoe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpoe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import tpoe_pkg::*;

  cfg_t                     shadow;
  logic [PRESCALE_BITS-1:0] pre_cnt;
  logic [7:0]               tmr_cnt;
  logic [31:0]              evt_cnt;
  logic                     pin_q;
  res_t                     timer_results_q[$];
  int                       fails = 0;

  // source cycles per timer tick, 0 when the clock is stopped
  function automatic int unsigned ratio_of(input logic [2:0] cs);
    case (cs)
      CS_DIV1:    return 1;
      CS_DIV8:    return 8;
      CS_DIV64:   return 64;
      CS_DIV256:  return 256;
      CS_DIV1024: return 1024;
      default:    return 0;
    endcase
  endfunction

  task automatic step_timer(input logic restart, output res_t r);
    int unsigned ratio;
    logic        tick;
    logic        ovf;
    logic        hit;
    logic        fire;
    logic [7:0]  old_cnt;
    logic [7:0]  new_cnt;
    ovf  = 1'b0;
    hit  = 1'b0;
    fire = 1'b0;
    if (restart) begin
      pre_cnt = '0;
      evt_cnt = '0;
      tmr_cnt = shadow.preload;
    end else begin
      ratio = ratio_of(shadow.clock_select);
      if (ratio != 0) begin
        tick    = (32'(pre_cnt) + 32'd1) >= ratio;
        pre_cnt = tick ? '0 : pre_cnt + 1'b1;
        if (tick) begin
          // match and overflow both look at the count before the tick
          old_cnt = tmr_cnt;
          hit     = (old_cnt == shadow.compare_value);
          ovf     = (old_cnt == 8'hFF);
          new_cnt = (shadow.mode && hit) ? 8'h00 : old_cnt + 8'd1;
          if (hit) begin
            case (shadow.pin_action)
              PIN_TOGGLE: pin_q = ~pin_q;
              PIN_CLEAR:  pin_q = 1'b0;
              PIN_SET:    pin_q = 1'b1;
              default:    ;
            endcase
          end
          if (shadow.mode ? hit : ovf) begin
            // divisor 0 behaves as 1; a lowered divisor fires at once
            if ({1'b0, evt_cnt} + 33'd1 >= {1'b0, shadow.events_divisor}) begin
              fire    = 1'b1;
              evt_cnt = '0;
              if (!shadow.mode) new_cnt = shadow.preload;
            end else begin
              evt_cnt = evt_cnt + 32'd1;
            end
          end
          tmr_cnt = new_cnt;
        end
      end
    end
    r.count         = tmr_cnt;
    r.overflow      = ovf;
    r.compare_match = hit;
    r.pin_level     = pin_q;
    r.event_res     = fire;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (!rst_n) begin
      shadow.mode           = 1'b0;
      shadow.clock_select   = CS_STOP;
      shadow.compare_value  = 8'd0;
      shadow.pin_action     = PIN_NONE;
      shadow.preload        = 8'd0;
      shadow.events_divisor = 32'd1;
      pre_cnt               = '0;
      tmr_cnt               = 8'd0;
      evt_cnt               = 32'd0;
      pin_q                 = 1'b0;
      timer_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:    shadow.mode           = cfg_wdata[0];
          REG_CLK_SEL: shadow.clock_select   = cfg_wdata[2:0];
          REG_COMPARE: shadow.compare_value  = cfg_wdata[7:0];
          REG_PIN_ACT: shadow.pin_action     = cfg_wdata[1:0];
          REG_PRELOAD: shadow.preload        = cfg_wdata[7:0];
          REG_EVT_DIV: shadow.events_divisor = cfg_wdata[31:0];
          default:     ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (timer_results_q.size() == 0) begin
          $error("result beat with nothing expected: count %0d", out_count);
          fails++;
        end else begin
          want = timer_results_q.pop_front();
          check_field("count", want.count, out_count);
          check_field("overflow", want.overflow, out_overflow);
          check_field("compare_match", want.compare_match, out_compare_match);
          check_field("pin_level", want.pin_level, out_pin_level);
          check_field("event_res", want.event_res, out_event_res);
        end
      end
      if (in_valid && !in_stall) begin
        step_timer(in_restart, got);
        timer_results_q.push_back(got);
      end
    end
    pending    <= timer_results_q.size();
    fail_count <= fails;
  end

endmodule

@@ dv/tb_timer8_prescaled_overflow_extender.sv @@
// ----------------------------------------------------------------------------
// Timer testbench top
// Drives source-cycle beats with random gaps and result stalls, reprograms
// the timer between phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_timer8_prescaled_overflow_extender;
  import tpoe_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [2:0] CS_SPARE6   = 3'd6;
  localparam logic [2:0] CS_SPARE7   = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_restart = 1'b0;
  logic                  out_stall  = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  wire logic             in_stall;
  wire logic             out_valid;
  wire logic [7:0]       out_count;
  wire logic             out_overflow;
  wire logic             out_compare_match;
  wire logic             out_pin_level;
  wire logic             out_event_res;
  int                    fail_count;
  int                    pending;
  int                    cycle_cnt = 0;
  bit                    idle_on   = 1'b1;

  always #10 clk = ~clk;

  timer8_prescaled_overflow_extender dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_count         (out_count),
    .out_overflow      (out_overflow),
    .out_compare_match (out_compare_match),
    .out_pin_level     (out_pin_level),
    .out_event_res     (out_event_res),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  timer8_prescaled_overflow_extender_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_count         (out_count),
    .out_overflow      (out_overflow),
    .out_compare_match (out_compare_match),
    .out_pin_level     (out_pin_level),
    .out_event_res     (out_event_res),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    return idle_on ? $urandom_range(0, 5) : 0;
  endfunction

  // result side: stall a random number of cycles, then take one beat
  initial begin : result_side
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // valid stays high across back-to-back beats; lowered only for a gap
  task automatic send_beat(input logic restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_run(input int n, input int restart_odds);
    for (int i = 0; i < n; i++) begin
      send_beat(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
    end
    in_valid <= 1'b0;
  endtask

  // wait for every expected beat, then let the pipeline empty
  task automatic settle();
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_timer(input logic m, input logic [2:0] cs, input logic [7:0] cmp,
                               input logic [1:0] act, input logic [7:0] pre,
                               input logic [31:0] evt_div, input bit junk);
    logic [CFG_IDX_W-1:0]  idx  [6];
    logic [CFG_DATA_W-1:0] data [6];
    logic [CFG_DATA_W-1:0] keep [5];
    idx  = '{REG_MODE, REG_CLK_SEL, REG_COMPARE, REG_PIN_ACT, REG_PRELOAD, REG_EVT_DIV};
    data = '{32'(m), 32'(cs), 32'(cmp), 32'(act), 32'(pre), evt_div};
    keep = '{32'h1, 32'h7, 32'hFF, 32'h3, 32'hFF};
    // junk fills the unused upper bits of the narrow registers
    if (junk) begin
      for (int i = 0; i < 5; i++) data[i] = data[i] | ($urandom() & ~keep[i]);
    end
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= data[i];
      @(posedge clk);
    end
    if (junk) begin
      cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
      cfg_wdata <= $urandom();
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic        m;
    logic [2:0]  cs;
    logic [7:0]  cmp;
    logic [7:0]  pre;
    logic [31:0] evt_div;
    int          n;
    int          sent;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clock stopped out of reset, then a restart
    send_beat(1'b0);
    send_beat(1'b0);
    send_beat(1'b1);
    in_valid <= 1'b0;
    settle();

    // normal mode: overflow and match on 255 together, divisor 0 reloads preload
    program_timer(1'b0, CS_DIV1, 8'd255, PIN_TOGGLE, 8'd253, 32'd0, 1'b0);
    send_beat(1'b1);
    send_run(4, 0);
    settle();

    // clear-on-compare with an event every second match
    program_timer(1'b1, CS_DIV1, 8'd2, PIN_SET, 8'd0, 32'd2, 1'b0);
    send_beat(1'b1);
    send_run(7, 0);
    settle();

    // compare 0 matches every tick; pin cleared; event count builds up
    program_timer(1'b1, CS_DIV1, 8'd0, PIN_CLEAR, 8'd0, 32'hFFFF_FFFF, 1'b0);
    send_beat(1'b1);
    send_run(3, 0);
    settle();

    // divisor lowered below the event count fires on the next match
    program_timer(1'b1, CS_DIV1, 8'd0, PIN_NONE, 8'd255, 32'd2, 1'b0);
    send_run(1, 0);
    settle();

    // unused clock select codes stop the timer
    program_timer(1'b0, CS_SPARE6, 8'd255, PIN_SET, 8'd255, 32'd1, 1'b1);
    send_run(1, 0);
    settle();
    program_timer(1'b0, CS_SPARE7, 8'd0, PIN_TOGGLE, 8'd0, 32'd1, 1'b1);
    send_run(1, 0);
    settle();

    // short random phases, state carried across reprogramming
    sent = 0;
    while (sent < 460) begin
      idle_on = ($urandom_range(0, 3) != 0);
      m = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 10))
        0:       cs = CS_STOP;
        1:       cs = $urandom_range(0, 1) ? CS_SPARE6 : CS_SPARE7;
        2:       cs = CS_DIV64;
        3, 4:    cs = CS_DIV8;
        10:      cs = $urandom_range(0, 1) ? CS_DIV256 : CS_DIV1024;
        default: cs = CS_DIV1;
      endcase
      case ($urandom_range(0, 5))
        0:       cmp = 8'd0;
        1:       cmp = 8'd255;
        2:       cmp = 8'($urandom_range(0, 255));
        default: cmp = 8'($urandom_range(0, 15));
      endcase
      // keep the count near the point where something happens
      if ($urandom_range(0, 4) == 0) pre = 8'($urandom_range(0, 255));
      else if (m) pre = 8'($urandom_range(0, cmp));
      else pre = 8'($urandom_range(192, 255));
      case ($urandom_range(0, 7))
        0:       evt_div = 32'd0;
        1:       evt_div = 32'hFFFF_FFFF;
        2:       evt_div = $urandom();
        default: evt_div = $urandom_range(1, 4);
      endcase
      program_timer(m, cs, cmp, 2'($urandom_range(0, 3)), pre, evt_div,
                    $urandom_range(0, 3) == 0);
      n = $urandom_range(40, 80);
      send_beat(1'($urandom_range(0, 1)));
      send_run(n - 1, 32);
      settle();
      sent += n;
    end

    // the /256 prescaler needs a long run to reach a tick
    idle_on = 1'b0;
    program_timer(1'b0, CS_DIV256, 8'd255, PIN_TOGGLE, 8'd255, 32'd1, 1'b0);
    send_beat(1'b1);
    send_run(300, 0);
    settle();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
